// File: rtl/set_union_intersection_engine_assert.svh
// ----------------------------------------------------------------------------
// Set union / intersection engine - assertion macros
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef SET_UNION_INTERSECTION_ENGINE_ASSERT_SVH
`define SET_UNION_INTERSECTION_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define SUIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define SUIE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/suie_pkg.sv
// ----------------------------------------------------------------------------
// Set union / intersection engine - package
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package suie_pkg;

  // Default store depth (elements per set)
  localparam int SET_DEPTH_DEF = 32;

  // Element width
  localparam int ELEM_W = 32;

  // Input command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD_A = 2'd1;
  localparam logic [1:0] CMD_LOAD_B = 2'd2;
  localparam logic [1:0] CMD_RUN    = 2'd3;

  // Operation register codes
  localparam logic OP_UNION     = 1'b0;
  localparam logic OP_INTERSECT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_a;     // write element into set A at waddr
    logic wr_b;     // write element into set B at waddr
    logic scan_a;   // read issued on A port is a compare read
    logic scan_b;   // read issued on B port is a compare read
    logic cand_a;   // capture A read data as candidate
    logic cand_b;   // capture B read data as candidate
    logic hit_clr;  // clear match flag
    logic take;     // candidate is a result
    logic finish;   // close the run, flush pending result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free; // output register can take an item this cycle
    logic hit;      // candidate matched during the last scan
  } dp_stat_t;

endpackage

// File: rtl/suie_datapath.sv
// ----------------------------------------------------------------------------
// Set union / intersection engine - datapath
// Set stores, candidate compare, one-deep result hold and output register.
// ----------------------------------------------------------------------------
module suie_datapath #(
  parameter int SET_DEPTH = suie_pkg::SET_DEPTH_DEF,
  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  suie_pkg::dp_cmd_t                 cmd,
  output suie_pkg::dp_stat_t                stat,
  input  logic [AW-1:0]                     waddr,
  input  logic [AW-1:0]                     a_raddr,
  input  logic [AW-1:0]                     b_raddr,
  input  logic signed [suie_pkg::ELEM_W-1:0] element,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [suie_pkg::ELEM_W-1:0] out_data,
  output logic                              out_last,
  output logic                              out_empty
);

  logic signed [suie_pkg::ELEM_W-1:0] mem_a [SET_DEPTH];
  logic signed [suie_pkg::ELEM_W-1:0] mem_b [SET_DEPTH];
  logic signed [suie_pkg::ELEM_W-1:0] a_rdata;
  logic signed [suie_pkg::ELEM_W-1:0] b_rdata;
  logic signed [suie_pkg::ELEM_W-1:0] cand;
  logic signed [suie_pkg::ELEM_W-1:0] pend_value;
  logic                               pend_valid;
  logic                               cmp_a;
  logic                               cmp_b;
  logic                               hit;
  logic                               out_load;

  // Set A store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[waddr] <= element;
    end
    a_rdata <= mem_a[a_raddr];
  end

  // Set B store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      mem_b[waddr] <= element;
    end
    b_rdata <= mem_b[b_raddr];
  end

  // Capture the candidate element
  always_ff @(posedge clk) begin
    if (cmd.cand_a) begin
      cand <= a_rdata;
    end else if (cmd.cand_b) begin
      cand <= b_rdata;
    end
  end

  // Compare read data in the cycle after its scan read, accumulate a match
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_a <= 1'b0;
      cmp_b <= 1'b0;
      hit   <= 1'b0;
    end else begin
      cmp_a <= cmd.scan_a;
      cmp_b <= cmd.scan_b;
      if (cmd.hit_clr) begin
        hit <= 1'b0;
      end else if ((cmp_a && (a_rdata == cand)) || (cmp_b && (b_rdata == cand))) begin
        hit <= 1'b1;
      end
    end
  end

  // Hold one result back so the final one can carry last
  assign out_load = (cmd.take && pend_valid) || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        pend_valid <= 1'b0;
      end else if (cmd.take) begin
        pend_valid <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_value <= cand;
    end
    if (out_load) begin
      out_data  <= (cmd.finish && !pend_valid) ? '0 : pend_value;
      out_last  <= cmd.finish;
      out_empty <= cmd.finish && !pend_valid;
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.hit      = hit;

endmodule

// File: rtl/suie_ctrl.sv
// ----------------------------------------------------------------------------
// Set union / intersection engine - controller
// Command decode, set counts, operation register and run sequencer.
// ----------------------------------------------------------------------------
module suie_ctrl #(
  parameter int SET_DEPTH = suie_pkg::SET_DEPTH_DEF,
  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1,
  localparam int CW = $clog2(SET_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic               cfg_wen,
  input  logic               cfg_wdata,
  input  suie_pkg::dp_stat_t stat,
  output suie_pkg::dp_cmd_t  cmd,
  output logic [AW-1:0]      waddr,
  output logic [AW-1:0]      a_raddr,
  output logic [AW-1:0]      b_raddr
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_UA_RD   = 4'd1;
  localparam logic [3:0] ST_UA_LD   = 4'd2;
  localparam logic [3:0] ST_UA_TAKE = 4'd3;
  localparam logic [3:0] ST_UB_RD   = 4'd4;
  localparam logic [3:0] ST_UB_LD   = 4'd5;
  localparam logic [3:0] ST_SCAN_A  = 4'd6;
  localparam logic [3:0] ST_SCAN_B  = 4'd7;
  localparam logic [3:0] ST_DRAIN   = 4'd8;
  localparam logic [3:0] ST_DECIDE  = 4'd9;
  localparam logic [3:0] ST_I_RD    = 4'd10;
  localparam logic [3:0] ST_I_LD    = 4'd11;
  localparam logic [3:0] ST_FIN     = 4'd12;

  localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

  logic [3:0]    state, state_next;
  logic [CW-1:0] cnt_a, cnt_a_next;
  logic [CW-1:0] cnt_b, cnt_b_next;
  logic [CW-1:0] idx_i, idx_i_next;
  logic [CW-1:0] idx_j, idx_j_next;
  logic          operation, operation_next;
  logic [CW-1:0] scan_b_lim;
  logic          keep;
  logic [3:0]    after_decide;

  // Union scans B below the candidate, intersection scans all of B
  assign scan_b_lim   = (operation == suie_pkg::OP_UNION) ? idx_i : cnt_b;
  assign keep         = (operation == suie_pkg::OP_UNION) ? !stat.hit : stat.hit;
  assign after_decide = (operation == suie_pkg::OP_UNION) ? ST_UB_RD : ST_I_RD;
  assign in_ready     = (state == ST_IDLE);

  // Next-state and command decode
  always_comb begin
    state_next     = state;
    cnt_a_next     = cnt_a;
    cnt_b_next     = cnt_b;
    idx_i_next     = idx_i;
    idx_j_next     = idx_j;
    operation_next = cfg_wen ? cfg_wdata : operation;
    cmd            = '0;
    waddr          = cnt_a[AW-1:0];
    a_raddr        = idx_i[AW-1:0];
    b_raddr        = idx_i[AW-1:0];

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            suie_pkg::CMD_CLEAR: begin
              cnt_a_next = '0;
              cnt_b_next = '0;
            end
            suie_pkg::CMD_LOAD_A: begin
              if (cnt_a < DEPTH_C) begin
                cmd.wr_a   = 1'b1;
                cnt_a_next = cnt_a + 1'b1;
              end
            end
            suie_pkg::CMD_LOAD_B: begin
              waddr = cnt_b[AW-1:0];
              if (cnt_b < DEPTH_C) begin
                cmd.wr_b   = 1'b1;
                cnt_b_next = cnt_b + 1'b1;
              end
            end
            suie_pkg::CMD_RUN: begin
              idx_i_next = '0;
              state_next = (operation == suie_pkg::OP_UNION) ? ST_UA_RD : ST_I_RD;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      // Union: pass all of A through
      ST_UA_RD: begin
        if (idx_i == cnt_a) begin
          idx_i_next = '0;
          state_next = ST_UB_RD;
        end else begin
          state_next = ST_UA_LD;
        end
      end
      ST_UA_LD: begin
        cmd.cand_a = 1'b1;
        state_next = ST_UA_TAKE;
      end
      ST_UA_TAKE: begin
        if (stat.out_free) begin
          cmd.take   = 1'b1;
          idx_i_next = idx_i + 1'b1;
          state_next = ST_UA_RD;
        end
      end

      // Union: fetch the next B candidate
      ST_UB_RD: begin
        if (idx_i == cnt_b) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_UB_LD;
        end
      end
      ST_UB_LD: begin
        cmd.cand_b  = 1'b1;
        cmd.hit_clr = 1'b1;
        idx_j_next  = '0;
        state_next  = ST_SCAN_A;
      end

      // Stream A past the candidate
      ST_SCAN_A: begin
        a_raddr = idx_j[AW-1:0];
        if (idx_j == cnt_a) begin
          idx_j_next = '0;
          state_next = ST_SCAN_B;
        end else begin
          cmd.scan_a = 1'b1;
          idx_j_next = idx_j + 1'b1;
        end
      end

      // Stream B past the candidate
      ST_SCAN_B: begin
        b_raddr = idx_j[AW-1:0];
        if (idx_j == scan_b_lim) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.scan_b = 1'b1;
          idx_j_next = idx_j + 1'b1;
        end
      end

      // Let the last compare land
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end

      // Keep or drop the candidate
      ST_DECIDE: begin
        if (!keep) begin
          idx_i_next = idx_i + 1'b1;
          state_next = after_decide;
        end else if (stat.out_free) begin
          cmd.take   = 1'b1;
          idx_i_next = idx_i + 1'b1;
          state_next = after_decide;
        end
      end

      // Intersection: fetch the next A candidate
      ST_I_RD: begin
        if (idx_i == cnt_a) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_I_LD;
        end
      end
      ST_I_LD: begin
        cmd.cand_a  = 1'b1;
        cmd.hit_clr = 1'b1;
        idx_j_next  = '0;
        state_next  = ST_SCAN_B;
      end

      // Flush the held result with last, or report an empty set
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      idx_i     <= '0;
      idx_j     <= '0;
      operation <= suie_pkg::OP_UNION;
    end else begin
      state     <= state_next;
      cnt_a     <= cnt_a_next;
      cnt_b     <= cnt_b_next;
      idx_i     <= idx_i_next;
      idx_j     <= idx_j_next;
      operation <= operation_next;
    end
  end

endmodule

// File: rtl/set_union_intersection_engine.sv
// ----------------------------------------------------------------------------
// Set union / intersection engine - top level
// Loads two sets of signed 32-bit elements and streams their union or
// intersection on a run command.
//
//   channel   direction  payload
//   s_*       in         tdata = element, tuser = command
//   m_*       out        tdata = result_value, tlast = last, tuser = empty_res
//   cfg_*     in         cfg_wdata = operation (0 union, 1 intersection)
//
// Clear and load items keep s_tready high; s_tready is low during a run.
// Union run: each A element passes straight through, then each B element is
// scanned against all of A and the B elements before it; intersection: each
// A element is scanned against all of B. Each set store has one read port.
// Reset (rst, synchronous) empties both sets and selects union.
// A stalled m_tready holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module set_union_intersection_engine #(
  parameter int SET_DEPTH = suie_pkg::SET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] element
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result_value
  output logic        m_tlast,
  output logic        m_tuser,   // [0] empty_res
  input  logic        cfg_wen,
  input  logic        cfg_wdata
);

  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

  suie_pkg::dp_cmd_t                  cmd;
  suie_pkg::dp_stat_t                 stat;
  logic [AW-1:0]                      waddr;
  logic [AW-1:0]                      a_raddr;
  logic [AW-1:0]                      b_raddr;
  logic signed [suie_pkg::ELEM_W-1:0] out_data;

  // Sequencer
  suie_ctrl #(
    .SET_DEPTH (SET_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd),
    .waddr     (waddr),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr)
  );

  // Stores and result path
  suie_datapath #(
    .SET_DEPTH (SET_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .waddr     (waddr),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .element   ($signed(s_tdata)),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data),
    .out_last  (m_tlast),
    .out_empty (m_tuser)
  );

  assign m_tdata = $unsigned(out_data);

endmodule

// File: rtl/suie_checker.sv
// ----------------------------------------------------------------------------
// Set union / intersection engine - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "set_union_intersection_engine_assert.svh"

module suie_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // A stalled result holds its payload
  `SUIE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result item changed while stalled")

  // An empty-result item is always the final item of its run
  `SUIE_ASSERT_IMP(a_empty_last, m_tvalid && m_tuser, m_tlast, "empty result without last")

  // A run item closes the input until the run is done
  `SUIE_ASSERT_NXT(a_run_busy, s_tvalid && s_tready && (s_tuser == suie_pkg::CMD_RUN), !s_tready, "input open right after a run item")

  // Clear and load items leave the input open
  `SUIE_ASSERT_NXT(a_load_ready, s_tvalid && s_tready && (s_tuser != suie_pkg::CMD_RUN), s_tready, "input closed after a load or clear item")

endmodule

bind set_union_intersection_engine suie_checker u_suie_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: dv/set_union_intersection_engine_checker.sv
// ----------------------------------------------------------------------------
// Set union / intersection engine - result checker
// Watches the config port and both stream channels, keeps a private copy of
// the two set stores, predicts the union or intersection on every run item
// and compares each delivered result item field by field, in order.
// ----------------------------------------------------------------------------
module set_union_intersection_engine_checker #(
  parameter int SET_DEPTH = suie_pkg::SET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] element
  input  logic [1:0]  s_tuser,   // [1:0] command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] result_value
  input  logic        m_tlast,
  input  logic        m_tuser,   // [0] empty_res
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef logic signed [suie_pkg::ELEM_W-1:0] elem_t;

  typedef struct packed {
    elem_t value;
    logic  last;
    logic  empty;
  } result_item_t;

  // Private copy of the block state
  elem_t        set_a [SET_DEPTH];
  elem_t        set_b [SET_DEPTH];
  int           size_a;
  int           size_b;
  logic         op_sel;
  result_item_t set_result_q[$];
  result_item_t want;
  int           n_fail = 0;
  int           n_pend = 0;

  assign fail_count = n_fail;
  assign pending    = n_pend;

  // Print one line per mismatch and count it
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, exp_val);
    n_fail++;
  endtask

  // Search the first n entries of set A or set B for a value
  function automatic bit occurs_in(bit from_b, elem_t v, int n);
    for (int i = 0; i < n; i++) begin
      if ((from_b ? set_b[i] : set_a[i]) == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the result items of one run and queue them
  task automatic compute_set_result();
    elem_t        found[$];
    result_item_t item;
    if (op_sel == suie_pkg::OP_UNION) begin
      for (int i = 0; i < size_a; i++) found.insert(found.size(), set_a[i]);
      for (int i = 0; i < size_b; i++) begin
        if (!occurs_in(1'b0, set_b[i], size_a) && !occurs_in(1'b1, set_b[i], i)) begin
          found.insert(found.size(), set_b[i]);
        end
      end
    end else begin
      for (int i = 0; i < size_a; i++) begin
        if (occurs_in(1'b1, set_a[i], size_b)) found.insert(found.size(), set_a[i]);
      end
    end
    if (found.size() == 0) begin
      item.value = '0;
      item.last  = 1'b1;
      item.empty = 1'b1;
      set_result_q.insert(set_result_q.size(), item);
    end else begin
      foreach (found[k]) begin
        item.value = found[k];
        item.last  = (k == found.size() - 1);
        item.empty = 1'b0;
        set_result_q.insert(set_result_q.size(), item);
      end
    end
  endtask

  // Sample handshakes at the clock edge, compare first, then predict
  always @(posedge clk) begin
    if (rst) begin
      size_a = 0;
      size_b = 0;
      op_sel = suie_pkg::OP_UNION;
      set_result_q.delete();
    end else begin
      if (cfg_wen) op_sel = cfg_wdata;

      if (m_tvalid && m_tready) begin
        if (set_result_q.size() == 0) begin
          report_mismatch("unexpected result item", m_tdata, '0);
        end else begin
          want = set_result_q.pop_front();
          // an empty result carries a zero value
          if (m_tdata !== want.value) begin
            report_mismatch("result_value", m_tdata, want.value);
          end
          if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
          if (m_tuser !== want.empty) report_mismatch("empty_res", m_tuser, want.empty);
        end
      end

      if (s_tvalid && s_tready) begin
        case (s_tuser)
          suie_pkg::CMD_CLEAR: begin
            size_a = 0;
            size_b = 0;
          end
          suie_pkg::CMD_LOAD_A: begin
            // drop loads into a full store
            if (size_a < SET_DEPTH) begin
              set_a[size_a] = s_tdata;
              size_a++;
            end
          end
          suie_pkg::CMD_LOAD_B: begin
            if (size_b < SET_DEPTH) begin
              set_b[size_b] = s_tdata;
              size_b++;
            end
          end
          default: compute_set_result();
        endcase
      end
    end
    n_pend = set_result_q.size();
  end

endmodule

// File: dv/tb_set_union_intersection_engine.sv
// ----------------------------------------------------------------------------
// Set union / intersection engine - testbench top
// Drives clear, load and run items with bursty timing and a stalling result
// receiver, switches between union and intersection while idle, and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_set_union_intersection_engine;

  localparam int SET_DEPTH    = suie_pkg::SET_DEPTH_DEF;
  localparam int NUM_ITEMS    = 110;
  localparam int SETTLE       = 32;
  localparam int LIMIT        = 200_000;

  // Receiver stall patterns
  localparam int RCV_ALWAYS   = 0;
  localparam int RCV_RANDOM   = 1;
  localparam int RCV_PERIODIC = 2;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;   // [31:0] element
  logic [1:0]  s_tuser   = suie_pkg::CMD_CLEAR;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;   // [31:0] result_value
  logic        m_tlast;
  logic        m_tuser;   // [0] empty_res
  logic        cfg_wen   = 1'b0;
  logic        cfg_wdata = suie_pkg::OP_UNION;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          burst_left  = 0;
  int          sent        = 0;
  int          rcv_mode    = RCV_ALWAYS;
  logic [7:0]  rcv_tick    = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_union_intersection_engine #(.SET_DEPTH(SET_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  set_union_intersection_engine_checker #(.SET_DEPTH(SET_DEPTH)) result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall the result side on a pattern picked anew whenever rcv_tick[5:0] is zero
  always @(posedge clk) begin
    rcv_tick <= rcv_tick + 8'd1;
    if (rcv_tick[5:0] == 6'd0) rcv_mode <= $urandom_range(RCV_ALWAYS, RCV_PERIODIC);
    case (rcv_mode)
      RCV_ALWAYS: m_tready <= 1'b1;
      RCV_RANDOM: m_tready <= 1'($urandom_range(0, 1));
      default:    m_tready <= (rcv_tick[1:0] == 2'd0);
    endcase
  end

  // End the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mix of overlapping small values, extremes and full-width random values
  function automatic logic [31:0] pick_element();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 32'($signed($urandom_range(0, 7)) - 4);
    if (sel < 13) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'hffff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  // Offer one item in bursts with random gaps; return at its acceptance edge
  task automatic send_item(logic [1:0] cmd, logic [31:0] elem);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(20, 40);
      end else begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 8);
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= elem;
    s_tuser  <= cmd;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // Drop valid, wait for every expected item, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_operation(logic op);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= op;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Clear (mostly), interleaved loads with an odd stray clear, then run;
  // sometimes rerun the same sets under a randomly chosen operation
  task automatic random_sequence(int a_len, int b_len);
    int   a_left;
    int   b_left;
    logic op;
    a_left = a_len;
    b_left = b_len;
    if ($urandom_range(0, 3) != 0) send_item(suie_pkg::CMD_CLEAR, $urandom);
    while (a_left + b_left > 0) begin
      if ($urandom_range(0, 29) == 0) send_item(suie_pkg::CMD_CLEAR, $urandom);
      if ($urandom_range(1, a_left + b_left) <= a_left) begin
        send_item(suie_pkg::CMD_LOAD_A, pick_element());
        a_left--;
      end else begin
        send_item(suie_pkg::CMD_LOAD_B, pick_element());
        b_left--;
      end
    end
    send_item(suie_pkg::CMD_RUN, $urandom);
    if ($urandom_range(0, 2) == 0) begin
      op = 1'($urandom_range(0, 1));
      write_operation(op);
      send_item(suie_pkg::CMD_RUN, $urandom);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty union, then clear with a nonzero element
    send_item(suie_pkg::CMD_RUN, 32'hdead_beef);
    send_item(suie_pkg::CMD_CLEAR, 32'hffff_ffff);
    // Extremes in A with a duplicate, duplicates and overlap in B
    send_item(suie_pkg::CMD_LOAD_A, 32'h7fff_ffff);
    send_item(suie_pkg::CMD_LOAD_A, 32'h8000_0000);
    send_item(suie_pkg::CMD_LOAD_A, 32'h0000_0000);
    send_item(suie_pkg::CMD_LOAD_A, 32'hffff_ffff);
    send_item(suie_pkg::CMD_LOAD_A, 32'h0000_0000);
    send_item(suie_pkg::CMD_LOAD_B, 32'hffff_ffff);
    send_item(suie_pkg::CMD_LOAD_B, 32'h0000_0005);
    send_item(suie_pkg::CMD_LOAD_B, 32'h0000_0005);
    send_item(suie_pkg::CMD_LOAD_B, 32'h8000_0000);
    send_item(suie_pkg::CMD_LOAD_B, 32'h1234_5678);
    send_item(suie_pkg::CMD_RUN, 32'h5555_aaaa);
    write_operation(suie_pkg::OP_INTERSECT);
    send_item(suie_pkg::CMD_RUN, 32'haaaa_5555);
    // Disjoint sets give an empty intersection, then one common element
    send_item(suie_pkg::CMD_CLEAR, 32'h0);
    send_item(suie_pkg::CMD_LOAD_A, 32'h1);
    send_item(suie_pkg::CMD_LOAD_B, 32'h2);
    send_item(suie_pkg::CMD_RUN, 32'h0);
    send_item(suie_pkg::CMD_LOAD_B, 32'h1);
    send_item(suie_pkg::CMD_RUN, 32'h0);
    write_operation(suie_pkg::OP_UNION);
    // Union with A empty and a duplicate in B
    send_item(suie_pkg::CMD_CLEAR, 32'h0);
    send_item(suie_pkg::CMD_LOAD_B, 32'h9);
    send_item(suie_pkg::CMD_LOAD_B, 32'h9);
    send_item(suie_pkg::CMD_RUN, 32'h0);

    // Random part: first overfill both stores for the longest result run
    random_sequence(34, 33);
    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_operation(1'($urandom_range(0, 1)));
      random_sequence($urandom_range(0, 6), $urandom_range(0, 6));
    end

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
